// ===== rtl/core/ptw_pkg.sv =====
// Shared types, constants and codes for the radix page table walker.
// No dependencies; every other file imports this package.
package ptw_pkg;

  localparam int LEVELS = 4;
  localparam int ENTRIES_PER_FRAME = 512;
  localparam int FRAME_POOL = 64;

  localparam int IDX_W = $clog2(ENTRIES_PER_FRAME);
  localparam int SLOT_W = (FRAME_POOL > 1) ? $clog2(FRAME_POOL) : 1;
  localparam int ALLOC_W = $clog2(FRAME_POOL + 1);
  localparam int DEPTH_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ENT_ADDR_W = SLOT_W + IDX_W;
  localparam int PAY_W = 40;
  localparam int VA_W = 48;
  localparam int ENT_W = PAY_W + 2;
  localparam int ENT_LEAF_BIT = PAY_W + 1;
  localparam int ENT_MARK_BIT = PAY_W;
  localparam int TOP_SHIFT = 39;
  localparam int LEVEL_BITS = 9;
  localparam int SPARES = 3;

  localparam logic [ENT_W-1:0] ENT_LEAF = {1'b1, 1'b0, {PAY_W{1'b0}}};
  localparam logic [ENT_W-1:0] ENT_CLEAR = '0;

  typedef enum logic [1:0] {
    OP_WALK = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_VISIT = 2'd0,
    KIND_WALK_DONE = 2'd1,
    KIND_INSERT_DONE = 2'd2,
    KIND_DELETE_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_ROOT = 3'd0,
    CFG_SHIFT_ONE = 3'd1,
    CFG_SHIFT_TWO = 3'd2,
    CFG_SHIFT_THREE = 3'd3,
    CFG_SHIFT_FOUR = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [47:0] virtual_address;
    logic [39:0] mapped_frame;
    logic huge_page;
    logic [39:0] spare_frame_a;
    logic [39:0] spare_frame_b;
    logic [39:0] spare_frame_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [51:0] entry_address;
    logic entry_is_valid_leaf;
    logic [1:0] walk_depth;
    logic [39:0] translated_frame;
    logic [5:0] page_shift;
    logic fault;
    logic [1:0] frames_consumed;
    logic error;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [39:0] root;
    logic [3:0][5:0] shift;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic [ENT_ADDR_W-1:0] addr;
    logic [ENT_W-1:0] data;
  } ent_wr_t;

  typedef struct packed {
    logic en;
    logic [SLOT_W-1:0] addr;
    logic [PAY_W-1:0] data;
  } frm_wr_t;

endpackage

// ===== rtl/core/ptw_entry_ram.sv =====
// Table entry store: one write port and one registered read port.
// Depends on ptw_pkg.
module ptw_entry_ram
  import ptw_pkg::*;
(
  input  logic clk,
  input  ent_wr_t wr,
  input  logic re,
  input  logic [ENT_ADDR_W-1:0] raddr,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [FRAME_POOL*ENTRIES_PER_FRAME];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ptw_frame_ram.sv =====
// Frame number of each table slot: one write port and one registered read port.
// Depends on ptw_pkg.
module ptw_frame_ram
  import ptw_pkg::*;
(
  input  logic clk,
  input  frm_wr_t wr,
  input  logic re,
  input  logic [SLOT_W-1:0] raddr,
  output logic [PAY_W-1:0] rdata
);

  logic [PAY_W-1:0] mem [FRAME_POOL];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ptw_seq.sv =====
// Sequencer that walks, inserts and deletes one level per pass over the stores.
// Depends on ptw_pkg; drives ptw_entry_ram and ptw_frame_ram.
module ptw_seq
  import ptw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_item,
  output ent_wr_t ent_wr,
  output logic ent_re,
  output logic [ENT_ADDR_W-1:0] ent_raddr,
  input  logic [ENT_W-1:0] ent_rdata,
  output frm_wr_t frm_wr,
  output logic frm_re,
  output logic [SLOT_W-1:0] frm_raddr,
  input  logic [PAY_W-1:0] frm_rdata
);

  localparam logic [DEPTH_W-1:0] DEPTH_LAST = DEPTH_W'(LEVELS - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_TWO = DEPTH_W'(LEVELS - 2);

  state_t state, state_next;
  in_item_t req;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [1:0] used, used_next;
  logic [ALLOC_W-1:0] alloc_cnt, alloc_cnt_next;
  logic [IDX_W-1:0] clr_cnt, clr_cnt_next;
  logic [SLOT_W-1:0] clr_slot, clr_slot_next;
  logic [ENT_W-1:0] clr_fill, clr_fill_next;
  kind_t done_kind, done_kind_next;
  logic [PAY_W-1:0] done_tf, done_tf_next;
  logic [5:0] done_ps, done_ps_next;
  logic done_fault, done_fault_next;
  logic done_err, done_err_next;
  out_item_t out_next;
  logic out_load;

  logic [IDX_W-1:0] idx;
  logic [PAY_W-1:0] frame;
  logic e_leaf, e_mark, link_ok, at_target, pool_full, out_free;
  logic [PAY_W-1:0] e_pay;
  logic [1:0] ps_sel;
  logic [PAY_W-1:0] spare;

  always_comb begin
    idx = '0;
    for (int d = 0; d < LEVELS; d++) begin
      if (depth == DEPTH_W'(d)) begin
        idx = req.virtual_address[(TOP_SHIFT - LEVEL_BITS * d) +: IDX_W];
      end
    end
  end

  always_comb begin
    e_leaf = ent_rdata[ENT_LEAF_BIT];
    e_mark = ent_rdata[ENT_MARK_BIT];
    e_pay = ent_rdata[PAY_W-1:0];
    link_ok = !e_leaf && e_mark && (e_pay < PAY_W'(FRAME_POOL));
    frame = (slot == '0) ? cfg.root : frm_rdata;
    at_target = req.huge_page ? (depth == DEPTH_TWO) : (depth == DEPTH_LAST);
    pool_full = (alloc_cnt >= ALLOC_W'(FRAME_POOL)) || (used == 2'(SPARES));
    out_free = !out_valid || !out_stall;
    ps_sel = 2'(LEVELS - 1 - int'(depth));
    unique case (used)
      2'd0: spare = req.spare_frame_a;
      2'd1: spare = req.spare_frame_b;
      default: spare = req.spare_frame_c;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (clr_cnt == IDX_W'(ENTRIES_PER_FRAME - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && (in_item.op != OP_NONE)) state_next = ST_READ;
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        unique case (op_t'(req.op))
          OP_WALK: begin
            if (out_free) begin
              if (!e_leaf && link_ok && depth != DEPTH_LAST) state_next = ST_READ;
              else state_next = ST_DONE;
            end
          end
          OP_INSERT: begin
            if (at_target || e_leaf) state_next = ST_DONE;
            else if (link_ok) state_next = ST_READ;
            else if (pool_full) state_next = ST_DONE;
            else state_next = ST_CLEAR;
          end
          default: begin
            if (!e_leaf && link_ok && depth != DEPTH_LAST) state_next = ST_READ;
            else state_next = ST_DONE;
          end
        endcase
      end
      ST_CLEAR: begin
        if (clr_cnt == IDX_W'(ENTRIES_PER_FRAME - 1)) state_next = ST_READ;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    slot_next = slot;
    depth_next = depth;
    used_next = used;
    alloc_cnt_next = alloc_cnt;
    clr_cnt_next = clr_cnt;
    clr_slot_next = clr_slot;
    clr_fill_next = clr_fill;
    done_kind_next = done_kind;
    done_tf_next = done_tf;
    done_ps_next = done_ps;
    done_fault_next = done_fault;
    done_err_next = done_err;
    ent_wr = '0;
    frm_wr = '0;
    ent_re = 1'b0;
    ent_raddr = {slot, idx};
    frm_re = 1'b0;
    frm_raddr = slot;
    out_load = 1'b0;
    out_next = '0;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        ent_wr.en = 1'b1;
        ent_wr.addr = {clr_slot, clr_cnt};
        ent_wr.data = clr_fill;
        clr_cnt_next = clr_cnt + 1'b1;
      end
      ST_IDLE: begin
        slot_next = '0;
        depth_next = '0;
        used_next = '0;
        done_tf_next = '0;
        done_ps_next = '0;
        done_fault_next = 1'b0;
        done_err_next = 1'b0;
        unique case (op_t'(in_item.op))
          OP_WALK: done_kind_next = KIND_WALK_DONE;
          OP_INSERT: done_kind_next = KIND_INSERT_DONE;
          default: done_kind_next = KIND_DELETE_DONE;
        endcase
      end
      ST_READ: begin
        ent_re = 1'b1;
        frm_re = 1'b1;
      end
      ST_EVAL: begin
        unique case (op_t'(req.op))
          OP_WALK: begin
            if (out_free) begin
              out_load = 1'b1;
              out_next.kind = KIND_VISIT;
              out_next.entry_address = {frame, idx, 3'b000};
              out_next.entry_is_valid_leaf = e_leaf && e_mark;
              out_next.walk_depth = 2'(depth);
              if (e_leaf && e_mark) begin
                done_tf_next = e_pay;
                done_ps_next = cfg.shift[ps_sel];
              end else if (!e_leaf && link_ok && depth != DEPTH_LAST) begin
                slot_next = e_pay[SLOT_W-1:0];
                depth_next = depth + 1'b1;
              end else begin
                done_fault_next = 1'b1;
              end
            end
          end
          OP_INSERT: begin
            if (at_target) begin
              ent_wr.en = 1'b1;
              ent_wr.addr = {slot, idx};
              ent_wr.data = {1'b1, 1'b1, req.mapped_frame};
            end else if (e_leaf) begin
              done_err_next = 1'b1;
            end else if (link_ok) begin
              slot_next = e_pay[SLOT_W-1:0];
              depth_next = depth + 1'b1;
            end else if (pool_full) begin
              done_err_next = 1'b1;
            end else begin
              ent_wr.en = 1'b1;
              ent_wr.addr = {slot, idx};
              ent_wr.data = {1'b0, 1'b1, PAY_W'(alloc_cnt)};
              frm_wr.en = 1'b1;
              frm_wr.addr = alloc_cnt[SLOT_W-1:0];
              frm_wr.data = spare;
              alloc_cnt_next = alloc_cnt + 1'b1;
              used_next = used + 1'b1;
              clr_slot_next = alloc_cnt[SLOT_W-1:0];
              clr_cnt_next = '0;
              clr_fill_next = (depth == DEPTH_TWO) ? ENT_LEAF : ENT_CLEAR;
              slot_next = alloc_cnt[SLOT_W-1:0];
              depth_next = depth + 1'b1;
            end
          end
          default: begin
            if (e_leaf) begin
              ent_wr.en = 1'b1;
              ent_wr.addr = {slot, idx};
              ent_wr.data = ENT_LEAF;
            end else if (link_ok && depth != DEPTH_LAST) begin
              slot_next = e_pay[SLOT_W-1:0];
              depth_next = depth + 1'b1;
            end else begin
              done_err_next = 1'b1;
            end
          end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next.kind = done_kind;
          out_next.last = 1'b1;
          out_next.error = done_err;
          out_next.fault = done_fault;
          out_next.translated_frame = done_tf;
          out_next.page_shift = done_ps;
          out_next.frames_consumed = (done_kind == KIND_INSERT_DONE) ? used : 2'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      clr_cnt <= '0;
      clr_slot <= '0;
      clr_fill <= ENT_CLEAR;
      alloc_cnt <= ALLOC_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_cnt_next;
      clr_slot <= clr_slot_next;
      clr_fill <= clr_fill_next;
      alloc_cnt <= alloc_cnt_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) req <= in_item;
    if (out_load) out_item <= out_next;
    slot <= slot_next;
    depth <= depth_next;
    used <= used_next;
    done_kind <= done_kind_next;
    done_tf <= done_tf_next;
    done_ps <= done_ps_next;
    done_fault <= done_fault_next;
    done_err <= done_err_next;
  end

  a_alloc_range: assert property (@(posedge clk) disable iff (rst)
    (alloc_cnt != '0) && (alloc_cnt <= ALLOC_W'(FRAME_POOL)))
    else $error("frame allocation count out of range");

  a_alloc_clears: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && alloc_cnt != $past(alloc_cnt)) |-> (state == ST_CLEAR))
    else $error("new frame not swept after allocation");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.fault) |->
      (out_item.translated_frame == '0 && out_item.page_shift == '0))
    else $error("faulting walk reported a translation");

endmodule

// ===== rtl/core/radix_page_table_walker_core.sv =====
// A walk reads and then evaluates one entry per visited level, emitting a visit item
// for each, then emits its done item; insert and delete also read and evaluate one
// entry per level, and each new table frame is swept entry by entry before the item
// goes on. One item at a time: in_stall is high outside the idle state. After reset
// the root frame is swept before the first item is taken; configuration resets to
// root 0 and page shifts 12, 21, 30, 39.
module radix_page_table_walker_core
  import ptw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [39:0] cfg_data
);

  cfg_t cfg;
  ent_wr_t ent_wr;
  logic ent_re;
  logic [ENT_ADDR_W-1:0] ent_raddr;
  logic [ENT_W-1:0] ent_rdata;
  frm_wr_t frm_wr;
  logic frm_re;
  logic [SLOT_W-1:0] frm_raddr;
  logic [PAY_W-1:0] frm_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root <= '0;
      cfg.shift[0] <= 6'd12;
      cfg.shift[1] <= 6'd21;
      cfg.shift[2] <= 6'd30;
      cfg.shift[3] <= 6'd39;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ROOT: cfg.root <= cfg_data;
        CFG_SHIFT_ONE: cfg.shift[0] <= cfg_data[5:0];
        CFG_SHIFT_TWO: cfg.shift[1] <= cfg_data[5:0];
        CFG_SHIFT_THREE: cfg.shift[2] <= cfg_data[5:0];
        CFG_SHIFT_FOUR: cfg.shift[3] <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  ptw_entry_ram u_entry_ram (
    .clk(clk),
    .wr(ent_wr),
    .re(ent_re),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  ptw_frame_ram u_frame_ram (
    .clk(clk),
    .wr(frm_wr),
    .re(frm_re),
    .raddr(frm_raddr),
    .rdata(frm_rdata)
  );

  ptw_seq u_seq (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .ent_wr(ent_wr),
    .ent_re(ent_re),
    .ent_raddr(ent_raddr),
    .ent_rdata(ent_rdata),
    .frm_wr(frm_wr),
    .frm_re(frm_re),
    .frm_raddr(frm_raddr),
    .frm_rdata(frm_rdata)
  );

endmodule

// ===== tb/tb_radix_page_table_walker_core.sv =====
// Self-checking testbench for radix_page_table_walker_core: it replays walks, inserts and
// deletes against its own page table predictor and compares every result item in order.
// Depends on ptw_pkg and the radix_page_table_walker_core RTL only.
`timescale 1ns / 1ps

module tb_radix_page_table_walker_core;
  import ptw_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 20;
  localparam logic [47:0] LEAF_ENT = 48'h8000_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [39:0] cfg_data = '0;

  logic [47:0] table_mem [0:FRAME_POOL*ENTRIES_PER_FRAME-1];
  logic [39:0] slot_base [0:FRAME_POOL-1];
  int unsigned slots_used;
  logic [39:0] root_reg;
  logic [5:0] shift_reg [0:3];

  in_item_t items_to_send[$];
  out_item_t results_due[$];
  int errors = 0;
  int cycles = 0;
  int received = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit long_hold_done = 0;

  radix_page_table_walker_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void expect_result(out_item_t r);
    results_due = {results_due, r};
  endfunction

  function automatic void enqueue_item(in_item_t it);
    items_to_send = {items_to_send, it};
  endfunction

  function automatic logic [8:0] level_idx(logic [47:0] va, int level);
    return 9'((va >> (48 - 9 * (LEVELS - level + 1))) & 48'h1FF);
  endfunction

  function automatic int ent_pos(int slot, logic [8:0] idx);
    return slot * ENTRIES_PER_FRAME + int'(idx);
  endfunction

  function automatic bit follow_link(logic [47:0] e, output int slot);
    slot = 0;
    if (e[47] || !e[46] || e[39:0] >= FRAME_POOL) return 0;
    slot = int'(e[39:0]);
    return 1;
  endfunction

  function automatic void push_done(kind_t k, logic [39:0] tf, logic [5:0] ps, logic flt,
                                    logic [1:0] fc, logic err);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.translated_frame = tf;
    r.page_shift = ps;
    r.fault = flt;
    r.frames_consumed = fc;
    r.error = err;
    r.last = 1'b1;
    expect_result(r);
  endfunction

  function automatic void model_walk(logic [47:0] va);
    int slot;
    int level;
    logic [8:0] i;
    logic [47:0] e;
    logic [39:0] fr;
    out_item_t r;
    slot = 0;
    for (level = LEVELS; level > 0; level--) begin
      i = level_idx(va, level);
      e = table_mem[ent_pos(slot, i)];
      fr = (slot == 0) ? root_reg : slot_base[slot];
      r = '0;
      r.kind = KIND_VISIT;
      r.entry_address = {fr, i, 3'b000};
      r.entry_is_valid_leaf = e[47] & e[46];
      r.walk_depth = 2'(LEVELS - level);
      expect_result(r);
      if (e[47]) begin
        if (e[46]) begin
          push_done(KIND_WALK_DONE, e[39:0], shift_reg[level-1], 1'b0, 2'd0, 1'b0);
          return;
        end
        break;
      end
      if (!follow_link(e, slot)) break;
    end
    push_done(KIND_WALK_DONE, '0, '0, 1'b1, 2'd0, 1'b0);
  endfunction

  function automatic void model_insert(in_item_t it);
    logic [39:0] spare [0:2];
    int slot;
    int nxt;
    int level;
    int used;
    int p;
    int k;
    logic [47:0] e;
    bit err;
    spare[0] = it.spare_frame_a;
    spare[1] = it.spare_frame_b;
    spare[2] = it.spare_frame_c;
    slot = 0;
    used = 0;
    err = 0;
    for (level = LEVELS; level > 0; level--) begin
      p = ent_pos(slot, level_idx(it.virtual_address, level));
      e = table_mem[p];
      if ((it.huge_page && level == 2) || (!it.huge_page && level == 1)) begin
        table_mem[p] = {2'b11, 6'b0, it.mapped_frame};
        break;
      end
      if (e[47]) begin
        err = 1;
        break;
      end
      if (!follow_link(e, nxt)) begin
        if (slots_used >= FRAME_POOL || used >= SPARES) begin
          err = 1;
          break;
        end
        nxt = int'(slots_used);
        slots_used++;
        slot_base[nxt] = spare[used];
        used++;
        for (k = 0; k < ENTRIES_PER_FRAME; k++)
          table_mem[nxt*ENTRIES_PER_FRAME+k] = (level == 2) ? LEAF_ENT : '0;
        table_mem[p] = {2'b01, 6'b0, 40'(nxt)};
      end
      slot = nxt;
    end
    push_done(KIND_INSERT_DONE, '0, '0, 1'b0, 2'(used), err);
  endfunction

  function automatic void model_delete(logic [47:0] va);
    int slot;
    int level;
    int p;
    logic [47:0] e;
    bit err;
    slot = 0;
    err = 1;
    for (level = LEVELS; level > 0; level--) begin
      p = ent_pos(slot, level_idx(va, level));
      e = table_mem[p];
      if (e[47]) begin
        table_mem[p] = LEAF_ENT;
        err = 0;
        break;
      end
      if (!follow_link(e, slot)) break;
    end
    push_done(KIND_DELETE_DONE, '0, '0, 1'b0, 2'd0, err);
  endfunction

  function automatic void apply_item(in_item_t it);
    case (op_t'(it.op))
      OP_WALK: model_walk(it.virtual_address);
      OP_INSERT: model_insert(it);
      OP_DELETE: model_delete(it.virtual_address);
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cycles % 2048 < 400 || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [8:0] pick_idx(int n);
    if ($urandom_range(0, 99) < 85) return 9'($urandom_range(0, n - 1));
    return 9'($urandom);
  endfunction

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [47:0] rand_va();
    logic [8:0] top;
    top = ($urandom_range(0, 1) == 0) ? 9'd0 : 9'd511;
    if ($urandom_range(0, 99) < 10) top = 9'($urandom);
    return {top, pick_idx(2), pick_idx(3), 9'($urandom), 12'($urandom)};
  endfunction

  function automatic in_item_t make_item(op_t op, logic [47:0] va, logic [39:0] ppn,
                                         logic huge);
    in_item_t it;
    it.op = op;
    it.virtual_address = va;
    it.mapped_frame = ppn;
    it.huge_page = huge;
    it.spare_frame_a = rand40();
    it.spare_frame_b = rand40();
    it.spare_frame_c = rand40();
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    op_t op;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_INSERT;
    else if (r < 75) op = OP_WALK;
    else if (r < 95) op = OP_DELETE;
    else op = OP_NONE;
    return make_item(op, rand_va(), rand40(), $urandom_range(0, 99) < 30);
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [39:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROOT) root_reg = value;
    else shift_reg[int'(idx) - 1] = value[5:0];
  endtask

  task automatic write_all(logic [39:0] root, logic [5:0] s1, logic [5:0] s2,
                           logic [5:0] s3, logic [5:0] s4);
    write_reg(CFG_ROOT, root);
    write_reg(CFG_SHIFT_ONE, {34'd0, s1});
    write_reg(CFG_SHIFT_TWO, {34'd0, s2});
    write_reg(CFG_SHIFT_THREE, {34'd0, s3});
    write_reg(CFG_SHIFT_FOUR, {34'd0, s4});
  endtask

  task automatic drain();
    @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("radix_page_table_walker_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_item(in_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          in_item <= items_to_send.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        received++;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item %p", $time, out_item);
        end else begin
          want = results_due.pop_front();
          if (out_item !== want) begin
            errors++;
            $display("%0t: expected %p", $time, want);
            $display("%0t: actual   %p", $time, out_item);
          end
        end
      end
      if (!long_hold_done && received >= 60) begin
        long_hold_done = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (cycles % 2048 < 400 || $urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    int ph;
    logic [47:0] va_a;
    logic [47:0] va_b;
    for (n = 0; n < FRAME_POOL * ENTRIES_PER_FRAME; n++) table_mem[n] = '0;
    for (n = 0; n < FRAME_POOL; n++) slot_base[n] = '0;
    slots_used = 1;
    root_reg = '0;
    shift_reg[0] = 6'd12;
    shift_reg[1] = 6'd21;
    shift_reg[2] = 6'd30;
    shift_reg[3] = 6'd39;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    va_a = 48'h0000_0000_0ABC;
    va_b = 48'hFFFF_FFFF_FFFF;
    @(negedge clk);
    enqueue_item(make_item(OP_WALK, va_a, '0, 1'b0));
    enqueue_item(make_item(OP_DELETE, va_b, '0, 1'b0));
    enqueue_item(make_item(OP_NONE, va_b, '1, 1'b1));
    enqueue_item(make_item(OP_INSERT, va_a, 40'hFF_FFFF_FFFF, 1'b0));
    enqueue_item(make_item(OP_WALK, va_a, '0, 1'b0));
    enqueue_item(make_item(OP_WALK, va_a ^ 48'h1000, '0, 1'b0));
    enqueue_item(make_item(OP_INSERT, va_b, '0, 1'b1));
    enqueue_item(make_item(OP_WALK, va_b, '0, 1'b0));
    enqueue_item(make_item(OP_INSERT, va_b, 40'h12_3456_789A, 1'b0));
    enqueue_item(make_item(OP_DELETE, va_b, '0, 1'b0));
    enqueue_item(make_item(OP_DELETE, va_b, '0, 1'b0));
    enqueue_item(make_item(OP_WALK, va_b, '0, 1'b0));
    enqueue_item(make_item(OP_INSERT, va_a, 40'h55_AAAA_5555, 1'b1));
    enqueue_item(make_item(OP_WALK, va_a, '0, 1'b0));
    enqueue_item(make_item(OP_DELETE, va_a, '0, 1'b0));
    enqueue_item(make_item(OP_WALK, va_a, '0, 1'b0));
    enqueue_item(make_item(OP_DELETE, 48'h8000_0000_0000, '0, 1'b0));
    enqueue_item(make_item(OP_WALK, 48'h0000_4000_0000, '0, 1'b0));
    drain();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_all(40'hFF_FFFF_FFFF, 6'd12, 6'd39, 6'd12, 6'd39);
        1: write_all(40'h00_0000_0000, 6'd39, 6'd12, 6'd63, 6'd0);
        default: write_all(rand40(), 6'd12, 6'd21, 6'd30, 6'd39);
      endcase
      repeat (SETTLE) @(negedge clk);
      for (n = 0; n < 140 + 5 * ph; n++) enqueue_item(random_item());
      drain();
    end

    if (errors == 0) begin
      $display("radix_page_table_walker_core: match");
    end else begin
      $display("radix_page_table_walker_core: mismatch");
    end
    $finish;
  end

endmodule
